### rtl/beaver_share_multiplier_assert.svh
// Assertion macros for the Beaver share multiplier RTL.
// Expects clk and rst in scope of the including module.
`ifndef BEAVER_SHARE_MULTIPLIER_ASSERT_SVH
`define BEAVER_SHARE_MULTIPLIER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bsm_pkg.sv
// Shared types and op codes for the Beaver share multiplier.
// No dependencies; imported by beaver_share_multiplier.
`default_nettype none

package bsm_pkg;

  localparam int DATA_BITS = 32;

  localparam logic [2:0] OP_MASK       = 3'd0;
  localparam logic [2:0] OP_OPEN       = 3'd1;
  localparam logic [2:0] OP_COMBINE    = 3'd2;
  localparam logic [2:0] OP_B2A_MASK   = 3'd3;
  localparam logic [2:0] OP_B2A_COMBINE = 3'd4;

  typedef struct packed {
    logic [2:0]           op;
    logic                 binary_mode;
    logic [DATA_BITS-1:0] left;
    logic [DATA_BITS-1:0] right;
    logic [DATA_BITS-1:0] triple_a;
    logic [DATA_BITS-1:0] triple_b;
    logic [DATA_BITS-1:0] triple_c;
    logic                 own_bit;
  } in_word_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] first;
    logic [DATA_BITS-1:0] second;
  } out_word_t;

endpackage

`default_nettype wire

### rtl/bsm_products.sv
// Registered product unit: the three ring products of a Beaver combine.
// Depends on nothing but its parameter; used by beaver_share_multiplier.
`default_nettype none

module bsm_products #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic [W-1:0] left,
  input  wire logic [W-1:0] right,
  input  wire logic [W-1:0] triple_a,
  input  wire logic [W-1:0] triple_b,
  output logic      [W-1:0] prod_lr,
  output logic      [W-1:0] prod_lb,
  output logic      [W-1:0] prod_ra
);

  always_ff @(posedge clk) begin
    if (load) begin
      prod_lr <= W'(left * right);
      prod_lb <= W'(left * triple_b);
      prod_ra <= W'(right * triple_a);
    end
  end

endmodule

`default_nettype wire

### rtl/beaver_share_multiplier.sv
// Throughput: one word per cycle; each stage holds under back-pressure.
// Stages: input register, products, ring sum, output select register.
// Reset (rst, synchronous, active high) clears all valid bits and
// party_index; payload registers are not reset.
// Depends on bsm_pkg and bsm_products.
`default_nettype none

module beaver_share_multiplier #(
  parameter int RING_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write_en,
  input  wire logic              cfg_write_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bsm_pkg::in_word_t in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bsm_pkg::out_word_t     out_word
);

  import bsm_pkg::*;

  localparam int W = (RING_BITS < DATA_BITS) ? RING_BITS : DATA_BITS;

  logic party_index;

  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  logic [2:0]   s1_op;
  logic         s1_bin;
  logic         s1_ob;
  logic [W-1:0] s1_l, s1_r, s1_a, s1_b, s1_c;

  // stage 2
  logic [2:0]   s2_op;
  logic         s2_bin;
  logic         s2_ob;
  logic [W-1:0] s2_c, s2_lin_first, s2_lin_second, s2_bcomb;
  logic [W-1:0] prod_lr, prod_lb, prod_ra;
  logic [W-1:0] lin_first_next, lin_second_next, bcomb_next;

  // stage 3
  logic [2:0]   s3_op;
  logic         s3_bin;
  logic         s3_ob;
  logic [W-1:0] s3_rsum, s3_lin_first, s3_lin_second, s3_bcomb;
  logic [W-1:0] rsum_next;

  logic [W-1:0] first_next, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      party_index <= 1'b0;
    end else if (cfg_write_en) begin
      party_index <= cfg_write_data;
    end
  end

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_op  <= in_word.op;
      s1_bin <= in_word.binary_mode;
      s1_ob  <= in_word.own_bit;
      s1_l   <= W'(in_word.left);
      s1_r   <= W'(in_word.right);
      s1_a   <= W'(in_word.triple_a);
      s1_b   <= W'(in_word.triple_b);
      s1_c   <= W'(in_word.triple_c);
    end
  end

  bsm_products #(
    .W(W)
  ) u_products (
    .clk      (clk),
    .load     (rdy2 && v1),
    .left     (s1_l),
    .right    (s1_r),
    .triple_a (s1_a),
    .triple_b (s1_b),
    .prod_lr  (prod_lr),
    .prod_lb  (prod_lb),
    .prod_ra  (prod_ra)
  );

  always_comb begin
    lin_first_next  = '0;
    lin_second_next = '0;
    unique case (s1_op)
      OP_MASK: begin
        lin_first_next  = s1_bin ? (s1_l ^ s1_a) : (s1_l + s1_a);
        lin_second_next = s1_bin ? (s1_r ^ s1_b) : (s1_r + s1_b);
      end
      OP_OPEN: begin
        lin_first_next = s1_bin ? (s1_l ^ s1_r) : (s1_l + s1_r);
      end
      OP_B2A_MASK: begin
        lin_first_next  = (party_index ? '0 : W'(s1_l[0])) + s1_a;
        lin_second_next = (party_index ? W'(s1_l[0]) : '0) + s1_b;
      end
      default: begin
        lin_first_next  = '0;
        lin_second_next = '0;
      end
    endcase
    bcomb_next = (party_index ? (s1_l & s1_r) : '0) ^ (s1_l & s1_b) ^ (s1_r & s1_a) ^ s1_c;
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      s2_op         <= s1_op;
      s2_bin        <= s1_bin;
      s2_ob         <= s1_ob;
      s2_c          <= s1_c;
      s2_lin_first  <= lin_first_next;
      s2_lin_second <= lin_second_next;
      s2_bcomb      <= bcomb_next;
    end
  end

  assign rsum_next = (party_index ? prod_lr : '0) - prod_lb - prod_ra + s2_c;

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      s3_op         <= s2_op;
      s3_bin        <= s2_bin;
      s3_ob         <= s2_ob;
      s3_rsum       <= rsum_next;
      s3_lin_first  <= s2_lin_first;
      s3_lin_second <= s2_lin_second;
      s3_bcomb      <= s2_bcomb;
    end
  end

  always_comb begin
    unique case (s3_op)
      OP_MASK, OP_OPEN, OP_B2A_MASK: begin
        first_next  = s3_lin_first;
        second_next = s3_lin_second;
      end
      OP_COMBINE: begin
        first_next  = s3_bin ? s3_bcomb : s3_rsum;
        second_next = '0;
      end
      OP_B2A_COMBINE: begin
        first_next  = W'(s3_ob) - (s3_rsum << 1);
        second_next = '0;
      end
      default: begin
        first_next  = '0;
        second_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      out_word.first  <= DATA_BITS'(first_next);
      out_word.second <= DATA_BITS'(second_next);
    end
  end

`include "beaver_share_multiplier_assert.svh"

  `BSM_ASSERT_NEXT(a_in_loads_s1, in_valid && in_ready, v1, "accepted word not in stage 1")
  `BSM_ASSERT_NOW(a_stall_full, !in_ready, v1 && v2 && v3 && out_valid, "stall with a bubble")
  `BSM_ASSERT_NEXT(a_s2_holds, v2 && !rdy3, v2 && $stable(s2_op), "stage 2 lost a held word")
  `BSM_ASSERT_NEXT(a_s3_to_out, v3 && rdy4, out_valid, "stage 3 word not delivered")

endmodule

`default_nettype wire
